[hw/rtl/wsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint steering decision package
// Shared command codes, register indexes, register widths and the flag word
// that passes between the geometry and decision stages.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Drive command codes.
    localparam int CMD_W = 3;
    typedef enum logic [CMD_W-1:0] {
        CMD_LEFT    = 3'd0,
        CMD_RIGHT   = 3'd1,
        CMD_FORWARD = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_ARRIVED = 3'd4
    } t_cmd;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DISTANCE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TAN_THRESHOLD = 4'd1;

    // Register widths and reset values.
    localparam int ARRIVE_W = 13;
    localparam int THR_W    = 16;
    localparam int THR_FRAC = 12;
    localparam logic [ARRIVE_W-1:0] ARRIVE_RESET = 13'd30;
    localparam logic [THR_W-1:0]    THR_RESET    = 16'd722;

    // Decision flags carried from the geometry stages.
    typedef struct packed {
        logic arrived;
        logic left;
        logic forward;
    } t_wsd_flags;

endpackage : wsd_pkg
`default_nettype wire

[hw/rtl/wsd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint steering decision channel interfaces
// Valid/ready channels for marker words, command words and register writes.
// ----------------------------------------------------------------------------

// Marker and target coordinates, one word per frame.
interface wsd_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] front_x;
    logic [COORD_BITS-1:0] front_y;
    logic [COORD_BITS-1:0] back_x;
    logic [COORD_BITS-1:0] back_y;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;

    modport source (output valid, front_x, front_y, back_x, back_y, target_x, target_y,
                    input ready);
    modport sink   (input valid, front_x, front_y, back_x, back_y, target_x, target_y,
                    output ready);
endinterface : wsd_in_if

// Drive command, one word per input word.
interface wsd_out_if;
    logic                       valid;
    logic                       ready;
    logic [wsd_pkg::CMD_W-1:0]  command;

    modport source (output valid, command, input ready);
    modport sink   (input valid, command, output ready);
endinterface : wsd_out_if

// Register write channel.
interface wsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wsd_pkg::CFG_IDX_W-1:0]   index;
    logic [wsd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : wsd_cfg_if
`default_nettype wire

[hw/rtl/wsd_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint steering configuration registers
// Holds the arrival distance and the turn tangent threshold.
// ----------------------------------------------------------------------------
module wsd_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    wsd_cfg_if.sink                          i_cfg,
    output logic [wsd_pkg::ARRIVE_W-1:0]     o_arrive_distance,
    output logic [wsd_pkg::THR_W-1:0]        o_turn_tan
);
    import wsd_pkg::*;

    logic [ARRIVE_W-1:0] r_arrive_distance;
    logic [THR_W-1:0]    r_turn_tan;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Register file; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrive_distance <= ARRIVE_RESET;
            r_turn_tan        <= THR_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ARRIVE_DISTANCE:    r_arrive_distance <= i_cfg.data[ARRIVE_W-1:0];
                REG_TURN_TAN_THRESHOLD: r_turn_tan        <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_arrive_distance = r_arrive_distance;
    assign o_turn_tan        = r_turn_tan;

endmodule : wsd_cfg_regs
`default_nettype wire

[hw/rtl/wsd_geom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint steering geometry stages
// Three register stages: vector setup and arrival check, products and
// squares, then cross, dot, distance compare and turn side.
// ----------------------------------------------------------------------------
module wsd_geom #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [COORD_BITS-1:0]        i_front_x,
    input  wire logic [COORD_BITS-1:0]        i_front_y,
    input  wire logic [COORD_BITS-1:0]        i_back_x,
    input  wire logic [COORD_BITS-1:0]        i_back_y,
    input  wire logic [COORD_BITS-1:0]        i_target_x,
    input  wire logic [COORD_BITS-1:0]        i_target_y,
    input  wire logic [wsd_pkg::ARRIVE_W-1:0] i_arrive_distance,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [2*COORD_BITS+2:0]           o_mag_cross,
    output logic [2*COORD_BITS+2:0]           o_mag_dot,
    output wsd_pkg::t_wsd_flags               o_flags
);
    import wsd_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int R_W   = C + 1;
    localparam int N_W   = C + 2;
    localparam int P_W   = 2 * C + 3;
    localparam int S_W   = 2 * C + 4;
    localparam int MAG_W = 2 * C + 3;
    localparam int SQ_W  = 2 * C;
    localparam int D_W   = 2 * C + 1;
    localparam int M_W   = (C + 1 > ARRIVE_W) ? C + 1 : ARRIVE_W;

    // Stage enables: a stage loads when empty or when its word moves on.
    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    // ---------------- Stage 1: axis, target vector, arrival ----------------
    logic signed [N_W-1:0] fx_s, fy_s, bx_s, by_s, tx_s, ty_s;
    logic [C:0]            sum_x, sum_y;
    logic [C-1:0]          cx, cy, ad_cx, ad_cy;
    logic [C:0]            manh;
    logic [C-1:0]          n_adfx, n_adfy, n_adbx, n_adby;

    logic signed [R_W-1:0] r_rx, r_ry;
    logic signed [N_W-1:0] r_nx, r_ny;
    logic [C-1:0]          r_adfx, r_adfy, r_adbx, r_adby;
    logic                  r_s1_arrived;

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        abs_diff = (a >= b) ? a - b : b - a;
    endfunction

    always_comb begin
        fx_s   = signed'({2'b00, i_front_x});
        fy_s   = signed'({2'b00, i_front_y});
        bx_s   = signed'({2'b00, i_back_x});
        by_s   = signed'({2'b00, i_back_y});
        tx_s   = signed'({2'b00, i_target_x});
        ty_s   = signed'({2'b00, i_target_y});
        // Truncated midpoint and Manhattan distance to the target.
        sum_x  = {1'b0, i_front_x} + {1'b0, i_back_x};
        sum_y  = {1'b0, i_front_y} + {1'b0, i_back_y};
        cx     = sum_x[C:1];
        cy     = sum_y[C:1];
        ad_cx  = abs_diff(i_target_x, cx);
        ad_cy  = abs_diff(i_target_y, cy);
        manh   = {1'b0, ad_cx} + {1'b0, ad_cy};
        n_adfx = abs_diff(i_front_x, i_target_x);
        n_adfy = abs_diff(i_front_y, i_target_y);
        n_adbx = abs_diff(i_back_x, i_target_x);
        n_adby = abs_diff(i_back_y, i_target_y);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rx         <= R_W'(fx_s - bx_s);
            r_ry         <= R_W'(fy_s - by_s);
            r_nx         <= (tx_s <<< 1) - fx_s - bx_s;
            r_ny         <= (ty_s <<< 1) - fy_s - by_s;
            r_adfx       <= n_adfx;
            r_adfy       <= n_adfy;
            r_adbx       <= n_adbx;
            r_adby       <= n_adby;
            r_s1_arrived <= M_W'(manh) <= M_W'(i_arrive_distance);
        end
    end

    // ---------------- Stage 2: cross and dot products, squares ----------------
    logic signed [P_W-1:0] r_p_nxry, r_p_nyrx, r_p_rxnx, r_p_ryny;
    logic [SQ_W-1:0]       r_sq_fx, r_sq_fy, r_sq_bx, r_sq_by;
    logic                  r_s2_arrived;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p_nxry     <= P_W'(r_nx) * P_W'(r_ry);
            r_p_nyrx     <= P_W'(r_ny) * P_W'(r_rx);
            r_p_rxnx     <= P_W'(r_rx) * P_W'(r_nx);
            r_p_ryny     <= P_W'(r_ry) * P_W'(r_ny);
            r_sq_fx      <= r_adfx * r_adfx;
            r_sq_fy      <= r_adfy * r_adfy;
            r_sq_bx      <= r_adbx * r_adbx;
            r_sq_by      <= r_adby * r_adby;
            r_s2_arrived <= r_s1_arrived;
        end
    end

    // ---------------- Stage 3: cross, dot, distances, turn side ----------------
    logic signed [S_W-1:0] cross_sum, dot;
    logic [D_W-1:0]        d_front, d_back;
    logic                  cross_pos, dot_pos, dot_zero;
    t_wsd_flags            n_flags;
    logic [MAG_W-1:0]      n_mag_cross, n_mag_dot;

    logic [MAG_W-1:0]      r_mag_cross, r_mag_dot;
    t_wsd_flags            r_flags;

    always_comb begin
        cross_sum   = S_W'(r_p_nxry) - S_W'(r_p_nyrx);
        dot         = S_W'(r_p_rxnx) + S_W'(r_p_ryny);
        d_front     = D_W'(r_sq_fx) + D_W'(r_sq_fy);
        d_back      = D_W'(r_sq_bx) + D_W'(r_sq_by);
        cross_pos   = !cross_sum[S_W-1] && (cross_sum != '0);
        dot_pos     = !dot[S_W-1] && (dot != '0);
        dot_zero    = (dot == '0);
        n_mag_cross = cross_sum[S_W-1] ? MAG_W'(-cross_sum) : MAG_W'(cross_sum);
        n_mag_dot   = dot[S_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
        // A perpendicular heading turns by the sign of cross alone.
        n_flags.arrived = r_s2_arrived;
        n_flags.left    = dot_zero ? cross_pos : (cross_pos == dot_pos);
        n_flags.forward = d_front <= d_back;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_mag_cross <= n_mag_cross;
            r_mag_dot   <= n_mag_dot;
            r_flags     <= n_flags;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    assign o_mag_cross = r_mag_cross;
    assign o_mag_dot   = r_mag_dot;
    assign o_flags     = r_flags;

endmodule : wsd_geom
`default_nettype wire

[hw/rtl/wsd_decide.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint steering decision stages
// Scales the dot magnitude by the tangent threshold, compares it with the
// cross magnitude and registers the final command word.
// ----------------------------------------------------------------------------
module wsd_decide #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [2*COORD_BITS+2:0]    i_mag_cross,
    input  wire logic [2*COORD_BITS+2:0]    i_mag_dot,
    input  wire wsd_pkg::t_wsd_flags        i_flags,
    input  wire logic [wsd_pkg::THR_W-1:0]  i_turn_tan,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [wsd_pkg::CMD_W-1:0]       o_command
);
    import wsd_pkg::*;

    localparam int MAG_W = 2 * COORD_BITS + 3;
    localparam int CMP_W = MAG_W + THR_W;

    logic en4, en5;
    logic r_v4, r_v5;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v5;

    // Stage 4: threshold times dot magnitude, cross magnitude in Q.12.
    logic [CMP_W-1:0]          r_thr_dot;
    logic [MAG_W+THR_FRAC-1:0] r_cross_q;
    t_wsd_flags                r_flags;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_thr_dot <= CMP_W'(i_turn_tan) * CMP_W'(i_mag_dot);
            r_cross_q <= {i_mag_cross, {THR_FRAC{1'b0}}};
            r_flags   <= i_flags;
        end
    end

    // Stage 5: command selection into the output register.
    logic turn;
    t_cmd n_cmd;
    t_cmd r_cmd;

    always_comb begin
        turn = CMP_W'(r_cross_q) > r_thr_dot;
        priority if (r_flags.arrived) begin
            n_cmd = CMD_ARRIVED;
        end else if (turn) begin
            n_cmd = r_flags.left ? CMD_LEFT : CMD_RIGHT;
        end else begin
            n_cmd = r_flags.forward ? CMD_FORWARD : CMD_REVERSE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
        end
    end

    assign o_command = r_cmd;

endmodule : wsd_decide
`default_nettype wire

[hw/rtl/waypoint_steering_decision.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waypoint steering decision
// Turns front marker, back marker and target positions into one drive
// command word: turn left, turn right, forward, reverse or arrived.
// ----------------------------------------------------------------------------
// The block is a five-stage pipeline that takes one coordinate word every
// clock cycle while the output is not stalled and presents the command words
// on the output in order. The stages are vector setup with the arrival check,
// the cross and dot products with the squared distances, their sums, the
// threshold multiply, and the command register that drives the output
// channel. A stall on the output holds every word in place; empty stages keep
// filling. The arrival distance applies to words accepted after the write and
// the threshold to words that reach the threshold multiply after it, so both
// are meant to be written while no word is in flight.
// ----------------------------------------------------------------------------
module waypoint_steering_decision #(
    parameter int COORD_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wsd_in_if.sink    i_in,
    wsd_out_if.source o_out,
    wsd_cfg_if.sink   i_cfg
);
    import wsd_pkg::*;

    localparam int MAG_W = 2 * COORD_BITS + 3;

    logic [ARRIVE_W-1:0] arrive_distance;
    logic [THR_W-1:0]    turn_tan;
    logic                geom_valid, decide_ready;
    logic [MAG_W-1:0]    mag_cross, mag_dot;
    t_wsd_flags          flags;

    // Register file.
    wsd_cfg_regs u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (i_cfg),
        .o_arrive_distance (arrive_distance),
        .o_turn_tan        (turn_tan)
    );

    // Geometry stages.
    wsd_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in.valid),
        .o_ready           (i_in.ready),
        .i_front_x         (i_in.front_x),
        .i_front_y         (i_in.front_y),
        .i_back_x          (i_in.back_x),
        .i_back_y          (i_in.back_y),
        .i_target_x        (i_in.target_x),
        .i_target_y        (i_in.target_y),
        .i_arrive_distance (arrive_distance),
        .o_valid           (geom_valid),
        .i_ready           (decide_ready),
        .o_mag_cross       (mag_cross),
        .o_mag_dot         (mag_dot),
        .o_flags           (flags)
    );

    // Threshold compare and output register.
    wsd_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (geom_valid),
        .o_ready     (decide_ready),
        .i_mag_cross (mag_cross),
        .i_mag_dot   (mag_dot),
        .i_flags     (flags),
        .i_turn_tan  (turn_tan),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_command   (o_out.command)
    );

endmodule : waypoint_steering_decision
`default_nettype wire
